>>> hdl/refcounted_entry_cache_unit_macros.svh
// assertion macros for the refcounted entry cache checker
// no dependencies; included by the checker file
`ifndef REFCOUNTED_ENTRY_CACHE_UNIT_MACROS_SVH
`define REFCOUNTED_ENTRY_CACHE_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RCEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcec check failed");

// consequent must hold in the cycle after the antecedent
`define RCEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcec check failed");

`endif

>>> hdl/rcec_pkg.sv
// shared types and codes for the refcounted entry cache
// no dependencies; used by the slot store, the top level and the checker
`default_nettype none

package rcec_pkg;

   localparam int SLOTS_DEFAULT = 32;
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef enum logic [1:0] {
      CMD_ACQUIRE = 2'd0,
      CMD_DUP     = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_MARK    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   // one slot as held in the store
   typedef struct packed {
      logic [15:0] key;
      logic        is_tagged;
      logic [7:0]  count;
      logic        valid;
   } entry_type;

endpackage

`default_nettype wire

>>> hdl/rcec_slot_store.sv
// slot table memory with one registered read port and one write port
// depends on rcec_pkg; never-written slots read as untagged, count zero, not valid
`default_nettype none

module rcec_slot_store #(
   parameter int SLOTS = rcec_pkg::SLOTS_DEFAULT,
   localparam int SW = (SLOTS > 2) ? $clog2(SLOTS) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [SW-1:0]       rd_addr,
   output rcec_pkg::entry_type      rd_entry,
   input  wire logic                wr_en,
   input  wire logic [SW-1:0]       wr_addr,
   input  wire rcec_pkg::entry_type wr_entry
);

   rcec_pkg::entry_type mem [SLOTS];
   rcec_pkg::entry_type rd_data_ff;
   logic [SLOTS-1:0]    written_ff;
   logic                rd_written_ff;

   // memory array, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // per-slot written flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   // unwritten slot shows its reset value
   assign rd_entry = rd_written_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

>>> hdl/refcounted_entry_cache_unit.sv
// refcounted entry cache: sequencer around the slot store
// depends on rcec_pkg and rcec_slot_store
//
//   channel | direction | handshake            | contents
//   req     | in        | req_tvalid/tready    | command, key, slot, links flag
//   rsp     | out       | rsp_tvalid/tready    | slot, status, flags, count
//
// acquire walks the slot store one slot per cycle through its single read
// port, and stops early on a key hit.
// dup, release and mark_valid read one slot and write it back.
// reset is synchronous; it clears the per-slot written flags at once, no sweep.
// a result waiting in the output register holds the last step of the next
// request until it is taken; the next request is accepted meanwhile.
`default_nettype none

module refcounted_entry_cache_unit #(
   parameter int SLOTS = rcec_pkg::SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = object_key[15:0], slot_index[20:16], links_gone[21], zero pad
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,
   // request: tuser = command[1:0]
   input  wire logic [1:0]  req_tuser,
   // result: tdata = result_slot[4:0], freshly_claimed[5], contents_valid[6],
   //         count_after[14:7], destroy_needed[15]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   // result: tuser = status[1:0]
   output logic [1:0]       rsp_tuser
);

   localparam int SW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SINGLE,
      S_EXEC
   } state_type;

   state_type           state_ff, state_in;
   rcec_pkg::cmd_type   cmd_ff, cmd_in;
   logic [15:0]         key_ff, key_in;
   logic [4:0]          idx_ff, idx_in;
   logic                links_ff, links_in;
   logic                oor_ff, oor_in;
   logic [SW-1:0]       scan_addr_ff, scan_addr_in;
   logic [SW-1:0]       data_addr_ff, data_addr_in;
   logic [SW-1:0]       target_ff, target_in;
   logic [SW-1:0]       free_slot_ff, free_slot_in;
   logic                hit_ff, hit_in;
   logic                free_found_ff, free_found_in;
   rcec_pkg::entry_type ent_ff, ent_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;

   logic                rd_en;
   logic [SW-1:0]       rd_addr;
   rcec_pkg::entry_type rd_entry;
   logic                wr_en;
   logic [SW-1:0]       wr_addr;
   rcec_pkg::entry_type wr_entry;

   logic                accept;
   rcec_pkg::cmd_type   req_cmd;
   logic                req_oor;
   logic                scan_hit;
   logic                fire;

   // results of the execute step
   logic                   want_wr;
   logic [4:0]             res_slot;
   rcec_pkg::status_type   res_status;
   logic                   res_fresh;
   logic                   res_valid;
   logic [7:0]             res_count;
   logic                   res_destroy;

   rcec_slot_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_cmd    = rcec_pkg::cmd_type'(req_tuser);
   assign req_oor    = (req_cmd != rcec_pkg::CMD_ACQUIRE) &&
                       (32'(req_tdata[20:16]) >= 32'(SLOTS));
   assign scan_hit   = rd_entry.is_tagged && (rd_entry.key == key_ff);
   assign fire       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // execute step: new slot contents and the result fields
   always_comb begin
      want_wr     = 1'b0;
      wr_entry    = ent_ff;
      res_slot    = 5'(target_ff);
      res_status  = rcec_pkg::STATUS_OK;
      res_fresh   = 1'b0;
      res_valid   = ent_ff.valid;
      res_count   = ent_ff.count;
      res_destroy = 1'b0;
      wr_addr     = target_ff;
      if (oor_ff) begin
         res_slot  = idx_ff;
         res_valid = 1'b0;
         res_count = 8'd0;
      end else begin
         unique case (cmd_ff) inside
            rcec_pkg::CMD_ACQUIRE, rcec_pkg::CMD_DUP: begin
               if (cmd_ff == rcec_pkg::CMD_ACQUIRE && !hit_ff) begin
                  if (free_found_ff) begin
                     // claim the first zero-count slot
                     want_wr            = 1'b1;
                     wr_addr            = free_slot_ff;
                     wr_entry.key       = key_ff;
                     wr_entry.is_tagged = 1'b1;
                     wr_entry.count     = 8'd1;
                     wr_entry.valid     = 1'b0;
                     res_slot           = 5'(free_slot_ff);
                     res_fresh          = 1'b1;
                     res_valid          = 1'b0;
                     res_count          = 8'd1;
                  end else begin
                     res_slot   = 5'd0;
                     res_status = rcec_pkg::STATUS_FULL;
                     res_valid  = 1'b0;
                     res_count  = 8'd0;
                  end
               end else if (ent_ff.count == rcec_pkg::COUNT_MAX) begin
                  res_status = rcec_pkg::STATUS_OVERFLOW;
               end else begin
                  want_wr        = 1'b1;
                  wr_entry.count = ent_ff.count + 8'd1;
                  res_count      = wr_entry.count;
               end
            end
            rcec_pkg::CMD_RELEASE: begin
               if (ent_ff.count == 8'd0) begin
                  res_status = rcec_pkg::STATUS_UNDERFLOW;
               end else begin
                  want_wr        = 1'b1;
                  wr_entry.count = ent_ff.count - 8'd1;
                  res_count      = wr_entry.count;
                  // last reference gone and no links: drop the object
                  if (wr_entry.count == 8'd0 && links_ff) begin
                     wr_entry.is_tagged = 1'b0;
                     wr_entry.valid     = 1'b0;
                     res_valid          = 1'b0;
                     res_destroy        = 1'b1;
                  end
               end
            end
            rcec_pkg::CMD_MARK: begin
               want_wr        = 1'b1;
               wr_entry.valid = 1'b1;
               res_valid      = 1'b1;
            end
            default: begin
               want_wr = 1'b0;
            end
         endcase
      end
   end

   assign wr_en = fire && want_wr;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      links_in      = links_ff;
      oor_in        = oor_ff;
      scan_addr_in  = scan_addr_ff;
      data_addr_in  = data_addr_ff;
      target_in     = target_ff;
      free_slot_in  = free_slot_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      ent_in        = ent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_addr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req_cmd;
               key_in        = req_tdata[15:0];
               idx_in        = req_tdata[20:16];
               links_in      = req_tdata[21];
               oor_in        = req_oor;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               if (req_cmd == rcec_pkg::CMD_ACQUIRE) begin
                  rd_en        = 1'b1;
                  rd_addr      = '0;
                  data_addr_in = '0;
                  scan_addr_in = SW'(1);
                  state_in     = S_SCAN;
               end else begin
                  rd_en     = !req_oor;
                  rd_addr   = SW'(req_tdata[20:16]);
                  target_in = SW'(req_tdata[20:16]);
                  state_in  = S_SINGLE;
               end
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               hit_in    = 1'b1;
               target_in = data_addr_ff;
               ent_in    = rd_entry;
               state_in  = S_EXEC;
            end else begin
               // remember the first zero-count slot for a miss
               if (rd_entry.count == 8'd0 && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = data_addr_ff;
               end
               if (data_addr_ff == LAST_SLOT) begin
                  state_in = S_EXEC;
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = scan_addr_ff;
                  data_addr_in = scan_addr_ff;
                  scan_addr_in = scan_addr_ff + SW'(1);
               end
            end
         end
         S_SINGLE: begin
            ent_in   = rd_entry;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_destroy, res_count, res_valid, res_fresh, res_slot};
               rsp_user_in  = res_status;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      links_ff      <= links_in;
      oor_ff        <= oor_in;
      scan_addr_ff  <= scan_addr_in;
      data_addr_ff  <= data_addr_in;
      target_ff     <= target_in;
      free_slot_ff  <= free_slot_in;
      hit_ff        <= hit_in;
      free_found_ff <= free_found_in;
      ent_ff        <= ent_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

>>> hdl/rcec_checker.sv
// port-level checks for the refcounted entry cache, bound to the top level
// depends on rcec_pkg and refcounted_entry_cache_unit_macros.svh
`default_nettype none
`include "refcounted_entry_cache_unit_macros.svh"

module rcec_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled result holds its contents
   `RCEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one request at a time: no accept right after an accept
   `RCEC_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   // fresh claim shows count one, not valid, status ok
   `RCEC_ASSERT_NOW(a_fresh_claim, clock, reset, rsp_tvalid && rsp_tdata[5], rsp_tuser == rcec_pkg::STATUS_OK && rsp_tdata[14:7] == 8'd1 && !rsp_tdata[6])

   // destroy only with the count at zero and the slot invalid
   `RCEC_ASSERT_NOW(a_destroy, clock, reset, rsp_tvalid && rsp_tdata[15], rsp_tuser == rcec_pkg::STATUS_OK && rsp_tdata[14:7] == 8'd0 && !rsp_tdata[6] && !rsp_tdata[5])

   // table full carries no other information
   `RCEC_ASSERT_NOW(a_full_empty, clock, reset, rsp_tvalid && rsp_tuser == rcec_pkg::STATUS_FULL, rsp_tdata == 16'd0)

endmodule

bind refcounted_entry_cache_unit rcec_checker u_checker (.*);

`default_nettype wire

>>> test/testbench.sv
// self-checking testbench for refcounted_entry_cache_unit
// depends on rcec_pkg and the cache rtl; drives requests, predicts results, checks responses
`timescale 1ns / 100ps

module testbench;

   import rcec_pkg::*;

   localparam int SLOT_COUNT     = SLOTS_DEFAULT;
   localparam int ITEM_TARGET    = 1150;
   localparam int KEY_POOL_SIZE  = 40;
   localparam int LATENCY_CYCLES = SLOT_COUNT + 2;
   localparam int DRAIN_CYCLES   = 2 * LATENCY_CYCLES;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AFTER     = 300;
   localparam int IDLE_LIMIT     = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int DIRECTED_ROWS  = 20;
   localparam logic [15:0] HOT_KEY = 16'hC0DE;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] key;
      logic [4:0]  slot;
      logic        links;
   } request_type;

   typedef struct packed {
      logic [4:0] slot;
      status_type status;
      logic       fresh;
      logic       valid;
      logic [7:0] count;
      logic       destroy;
   } reply_type;

   typedef struct packed {
      request_type req;
      logic        typed;
      reply_type   want;
   } row_type;

   localparam reply_type NO_REPLY = '0;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // shadow copy of the slot table
   logic [15:0] entry_key    [SLOT_COUNT];
   logic        entry_tagged [SLOT_COUNT];
   logic [7:0]  entry_count  [SLOT_COUNT];
   logic        entry_valid  [SLOT_COUNT];

   reply_type   pending_replies [$];
   logic [15:0] key_pool [KEY_POOL_SIZE];

   int sent_count     = 0;
   int checked_count  = 0;
   int failure_count  = 0;
   int burst_left     = 0;
   int idle_cycles    = 0;
   int claim_count    = 0;
   int full_count     = 0;
   int overflow_count = 0;
   int underflow_count = 0;
   int destroy_count  = 0;

   // directed table: fields at their extremes and several special cases
   row_type directed_rows [DIRECTED_ROWS] = '{
      // claim on an empty table, all-zero key
      '{'{CMD_ACQUIRE, 16'h0000, 5'd0, 1'b0}, 1'b1, '{5'd0, STATUS_OK, 1'b1, 1'b0, 8'd1, 1'b0}},
      // claim of the all-ones key takes the next free slot
      '{'{CMD_ACQUIRE, 16'hFFFF, 5'd31, 1'b1}, 1'b1, '{5'd1, STATUS_OK, 1'b1, 1'b0, 8'd1, 1'b0}},
      // hit on a tagged key
      '{'{CMD_ACQUIRE, 16'h0000, 5'd31, 1'b1}, 1'b1, '{5'd0, STATUS_OK, 1'b0, 1'b0, 8'd2, 1'b0}},
      '{'{CMD_MARK, 16'hFFFF, 5'd0, 1'b1}, 1'b1, '{5'd0, STATUS_OK, 1'b0, 1'b1, 8'd2, 1'b0}},
      '{'{CMD_DUP, 16'hFFFF, 5'd0, 1'b0}, 1'b1, '{5'd0, STATUS_OK, 1'b0, 1'b1, 8'd3, 1'b0}},
      // release of an untagged slot with a zero count
      '{'{CMD_RELEASE, 16'h0000, 5'd31, 1'b1}, 1'b1,
        '{5'd31, STATUS_UNDERFLOW, 1'b0, 1'b0, 8'd0, 1'b0}},
      // dup, mark and release act on an untagged slot too
      '{'{CMD_DUP, 16'h0000, 5'd31, 1'b0}, 1'b1, '{5'd31, STATUS_OK, 1'b0, 1'b0, 8'd1, 1'b0}},
      '{'{CMD_MARK, 16'h0000, 5'd31, 1'b0}, 1'b1, '{5'd31, STATUS_OK, 1'b0, 1'b1, 8'd1, 1'b0}},
      '{'{CMD_RELEASE, 16'h0000, 5'd31, 1'b1}, 1'b1,
        '{5'd31, STATUS_OK, 1'b0, 1'b0, 8'd0, 1'b1}},
      // last reference dropped with links left: slot stays tagged
      '{'{CMD_RELEASE, 16'hFFFF, 5'd1, 1'b0}, 1'b1, '{5'd1, STATUS_OK, 1'b0, 1'b0, 8'd0, 1'b0}},
      // zero-count slot still tagged with the old key gets reused
      '{'{CMD_ACQUIRE, 16'h1234, 5'd1, 1'b0}, 1'b1, '{5'd1, STATUS_OK, 1'b1, 1'b0, 8'd1, 1'b0}},
      // old key is gone, so it claims a new slot
      '{'{CMD_ACQUIRE, 16'hFFFF, 5'd0, 1'b0}, 1'b1, '{5'd2, STATUS_OK, 1'b1, 1'b0, 8'd1, 1'b0}},
      '{'{CMD_RELEASE, 16'h5A5A, 5'd0, 1'b1}, 1'b0, NO_REPLY},
      '{'{CMD_RELEASE, 16'hA5A5, 5'd0, 1'b1}, 1'b0, NO_REPLY},
      '{'{CMD_RELEASE, 16'h0F0F, 5'd0, 1'b1}, 1'b0, NO_REPLY},
      '{'{CMD_MARK, 16'hF0F0, 5'd2, 1'b0}, 1'b0, NO_REPLY},
      '{'{CMD_RELEASE, 16'h8001, 5'd2, 1'b0}, 1'b0, NO_REPLY},
      // hit on a tagged slot whose count is zero
      '{'{CMD_ACQUIRE, 16'hFFFF, 5'd16, 1'b1}, 1'b0, NO_REPLY},
      '{'{CMD_DUP, 16'hA5A5, 5'd5, 1'b1}, 1'b0, NO_REPLY},
      '{'{CMD_RELEASE, 16'h7FFE, 5'd5, 1'b0}, 1'b0, NO_REPLY}
   };

   refcounted_entry_cache_unit #(
      .SLOTS (SLOT_COUNT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // apply one request to the shadow table and return the result it yields
   function automatic reply_type apply_request(request_type r);
      reply_type y;
      int        found;
      int        s;
      y     = '0;
      found = -1;
      if (r.cmd == CMD_ACQUIRE) begin
         // lookup among tagged slots first
         for (s = 0; s < SLOT_COUNT; s++) begin
            if (found < 0 && entry_tagged[s] && entry_key[s] == r.key) found = s;
         end
         if (found >= 0) begin
            if (entry_count[found] == COUNT_MAX) y.status = STATUS_OVERFLOW;
            else entry_count[found] = entry_count[found] + 8'd1;
            y.slot  = 5'(found);
            y.valid = entry_valid[found];
            y.count = entry_count[found];
         end else begin
            // miss: claim the lowest zero-count slot
            for (s = 0; s < SLOT_COUNT; s++) begin
               if (found < 0 && entry_count[s] == 8'd0) found = s;
            end
            if (found >= 0) begin
               entry_key[found]    = r.key;
               entry_tagged[found] = 1'b1;
               entry_count[found]  = 8'd1;
               entry_valid[found]  = 1'b0;
               y.slot  = 5'(found);
               y.fresh = 1'b1;
               y.count = 8'd1;
            end else begin
               y.status = STATUS_FULL;
            end
         end
         return y;
      end
      s      = int'(r.slot);
      y.slot = r.slot;
      case (r.cmd)
         CMD_DUP: begin
            if (entry_count[s] == COUNT_MAX) y.status = STATUS_OVERFLOW;
            else entry_count[s] = entry_count[s] + 8'd1;
         end
         CMD_RELEASE: begin
            if (entry_count[s] == 8'd0) begin
               y.status = STATUS_UNDERFLOW;
            end else begin
               entry_count[s] = entry_count[s] - 8'd1;
               if (entry_count[s] == 8'd0 && r.links) begin
                  entry_tagged[s] = 1'b0;
                  entry_valid[s]  = 1'b0;
                  y.destroy       = 1'b1;
               end
            end
         end
         default: begin
            entry_valid[s] = 1'b1;
         end
      endcase
      y.valid = entry_valid[s];
      y.count = entry_count[s];
      return y;
   endfunction

   // random slot that holds references, or any slot when none does
   function automatic logic [4:0] pick_busy_slot();
      int busy [SLOT_COUNT];
      int n;
      n = 0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (entry_count[s] != 8'd0) begin
            busy[n] = s;
            n++;
         end
      end
      if (n == 0) return 5'($urandom_range(0, SLOT_COUNT - 1));
      return 5'(busy[$urandom_range(0, n - 1)]);
   endfunction

   function automatic request_type make_request(cmd_type cmd, logic [15:0] key,
                                                logic [4:0] slot, logic links);
      request_type r;
      r.cmd   = cmd;
      r.key   = key;
      r.slot  = slot;
      r.links = links;
      return r;
   endfunction

   // offer one request in bursts with random gaps, then record its expected result
   task automatic offer_request(input request_type r, input logic typed,
                                input reply_type typed_reply);
      reply_type predicted;
      int        gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.links, r.slot, r.key};
      req_tuser  <= r.cmd;
      do @(posedge clock); while (!req_tready);
      predicted = apply_request(r);
      pending_replies.push_back(typed ? typed_reply : predicted);
      sent_count++;
      if (predicted.fresh) claim_count++;
      if (predicted.destroy) destroy_count++;
      case (predicted.status)
         STATUS_FULL:      full_count++;
         STATUS_OVERFLOW:  overflow_count++;
         STATUS_UNDERFLOW: underflow_count++;
         default: ;
      endcase
   endtask

   // response checker
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.slot    = rsp_tdata[4:0];
         got.fresh   = rsp_tdata[5];
         got.valid   = rsp_tdata[6];
         got.count   = rsp_tdata[14:7];
         got.destroy = rsp_tdata[15];
         got.status  = status_type'(rsp_tuser);
         checked_count++;
         if (pending_replies.size() == 0) begin
            failure_count++;
            if (failure_count <= REPORT_LIMIT)
               $display("unexpected result: slot %0d status %0d count %0d",
                        got.slot, got.status, got.count);
         end else begin
            want = pending_replies.pop_front();
            if (got.slot !== want.slot || got.status !== want.status ||
                got.fresh !== want.fresh || got.valid !== want.valid ||
                got.count !== want.count || got.destroy !== want.destroy) begin
               failure_count++;
               if (failure_count <= REPORT_LIMIT)
                  $display({"mismatch on result %0d: expected slot %0d status %0d fresh %0b",
                            " valid %0b count %0d destroy %0b, got slot %0d status %0d",
                            " fresh %0b valid %0b count %0d destroy %0b"},
                           checked_count, want.slot, want.status, want.fresh, want.valid,
                           want.count, want.destroy, got.slot, got.status, got.fresh,
                           got.valid, got.count, got.destroy);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // receiver stalls on its own pattern, with one long hold-off
   initial begin
      int  mode;
      int  len;
      logic held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         len  = $urandom_range(20, 120);
         repeat (len) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= ~rsp_tready;
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
         if (!held && checked_count >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      cmd_type     cmd;
      logic [15:0] key;
      logic [4:0]  slot;
      logic        links;
      logic        filling;
      int          phase_left;
      int          pick;
      int          hot_slot;

      for (int s = 0; s < SLOT_COUNT; s++) begin
         entry_key[s]    = '0;
         entry_tagged[s] = 1'b0;
         entry_count[s]  = '0;
         entry_valid[s]  = 1'b0;
      end
      for (int k = 0; k < KEY_POOL_SIZE; k++) key_pool[k] = 16'($urandom);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      // drive one slot past its count limit, then release it back to zero
      offer_request(make_request(CMD_ACQUIRE, HOT_KEY, 5'($urandom), 1'($urandom)),
                    1'b0, NO_REPLY);
      hot_slot = -1;
      for (int s = 0; s < SLOT_COUNT; s++)
         if (entry_tagged[s] && entry_key[s] == HOT_KEY) hot_slot = s;
      if (hot_slot >= 0) begin
         while (entry_count[hot_slot] != COUNT_MAX)
            offer_request(make_request(CMD_DUP, 16'($urandom), 5'(hot_slot), 1'($urandom)),
                          1'b0, NO_REPLY);
         repeat (2)
            offer_request(make_request(CMD_DUP, 16'($urandom), 5'(hot_slot), 1'($urandom)),
                          1'b0, NO_REPLY);
         offer_request(make_request(CMD_ACQUIRE, HOT_KEY, 5'($urandom), 1'($urandom)),
                       1'b0, NO_REPLY);
         while (entry_count[hot_slot] != 8'd0)
            offer_request(make_request(CMD_RELEASE, 16'($urandom), 5'(hot_slot),
                                       1'($urandom)), 1'b0, NO_REPLY);
      end

      // random traffic alternating fill-heavy and drain-heavy phases
      filling    = 1'b0;
      phase_left = 0;
      while (sent_count < ITEM_TARGET) begin
         if (phase_left == 0) begin
            filling    = ~filling;
            phase_left = $urandom_range(40, 140);
         end
         phase_left--;
         pick = $urandom_range(0, 99);
         if (filling) begin
            if (pick < 55)      cmd = CMD_ACQUIRE;
            else if (pick < 70) cmd = CMD_DUP;
            else if (pick < 82) cmd = CMD_RELEASE;
            else                cmd = CMD_MARK;
         end else begin
            if (pick < 15)      cmd = CMD_ACQUIRE;
            else if (pick < 25) cmd = CMD_DUP;
            else if (pick < 80) cmd = CMD_RELEASE;
            else                cmd = CMD_MARK;
         end
         key   = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                            : 16'($urandom);
         slot  = ($urandom_range(0, 6) != 0) ? pick_busy_slot()
                                             : 5'($urandom_range(0, SLOT_COUNT - 1));
         links = filling ? 1'($urandom) : 1'($urandom_range(0, 9) < 7);
         offer_request(make_request(cmd, key, slot, links), 1'b0, NO_REPLY);
      end
      req_tvalid <= 1'b0;

      // wait for outstanding results, then watch for strays
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests and %0d results: %0d claims, %0d destroys",
               sent_count, checked_count, claim_count, destroy_count);
      $display("status cases seen: %0d table full, %0d overflow, %0d release at zero",
               full_count, overflow_count, underflow_count);
      if (failure_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d failing results", failure_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
